// ===== rtl/core/rtnb_pkg.sv =====
// ----------------------------------------------------------------------------
// rtnb_pkg
// shared types and constants for the radix tree node builder
// ----------------------------------------------------------------------------
package rtnb_pkg;

	localparam int unsigned MaxObjects = 1024;
	localparam int unsigned IdxW       = $clog2(MaxObjects);
	localparam int unsigned CntW       = IdxW + 1;
	localparam int unsigned SIdxW      = IdxW + 3;  // signed index width
	localparam int unsigned KeyW       = 32;
	localparam int unsigned QDepth     = 2;

	typedef enum logic {
		REQ_LOAD  = 1'b0,
		REQ_QUERY = 1'b1
	} req_type_t;

	typedef enum logic {
		ST_OK      = 1'b0,
		ST_BAD_IDX = 1'b1
	} status_t;

	// item handed from front to back
	typedef struct packed {
		logic            is_query;
		logic [IdxW-1:0] position;
		logic [KeyW-1:0] key_value;
	} cmd_t;

	typedef struct packed {
		logic [IdxW-1:0] range_first;
		logic [IdxW-1:0] range_last;
		logic [IdxW-1:0] split_position;
		logic            first_child_is_leaf;
		logic            second_child_is_leaf;
		logic            status;
	} res_t;

	// leading zero count, 32 for zero
	function automatic logic [5:0] lzc32(input logic [31:0] v);
		logic [5:0] c;
		logic       found;
		c     = 6'd32;
		found = 1'b0;
		for (int i = 31; i >= 0; i--) begin
			if (!found && v[i]) begin
				c     = 6'(31 - i);
				found = 1'b1;
			end
		end
		return c;
	endfunction

endpackage

// ===== rtl/core/rtnb_req_if.sv =====
// ----------------------------------------------------------------------------
// rtnb_req_if / rtnb_rsp_if
// valid/ready channels for request and result items
// ----------------------------------------------------------------------------
interface rtnb_req_if import rtnb_pkg::*; ();
	logic            valid;
	logic            ready;
	logic            req_type;
	logic [IdxW-1:0] position;
	logic [KeyW-1:0] key_value;
	modport source (output valid, req_type, position, key_value, input ready);
	modport sink   (input valid, req_type, position, key_value, output ready);
endinterface

interface rtnb_rsp_if import rtnb_pkg::*; ();
	logic            valid;
	logic            ready;
	logic [IdxW-1:0] range_first;
	logic [IdxW-1:0] range_last;
	logic [IdxW-1:0] split_position;
	logic            first_child_is_leaf;
	logic            second_child_is_leaf;
	logic            status;
	modport source (output valid, range_first, range_last, split_position,
		first_child_is_leaf, second_child_is_leaf, status, input ready);
	modport sink   (input valid, range_first, range_last, split_position,
		first_child_is_leaf, second_child_is_leaf, status, output ready);
endinterface

// ===== rtl/core/rtnb_front.sv =====
// ----------------------------------------------------------------------------
// rtnb_front
// accepts request items and queues them for the back end
// ----------------------------------------------------------------------------
module rtnb_front import rtnb_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	rtnb_req_if.sink    req,
	output logic        cmd_valid,
	output cmd_t        cmd,
	input  logic        cmd_pop
);
	cmd_t        fifo_q [QDepth];
	logic        wr_q, rd_q;
	logic [1:0]  cnt_q;
	logic        push;

	assign req.ready = (cnt_q != 2'(QDepth));
	assign push      = req.valid && req.ready;
	assign cmd_valid = (cnt_q != 2'd0);
	assign cmd       = fifo_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) begin
			fifo_q[wr_q] <= '{is_query: (req.req_type == REQ_QUERY),
				position: req.position, key_value: req.key_value};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) wr_q <= ~wr_q;
			if (cmd_pop) rd_q <= ~rd_q;
			cnt_q <= cnt_q + 2'(push) - 2'(cmd_pop);
		end
	end
endmodule

// ===== rtl/core/rtnb_back.sv =====
// ----------------------------------------------------------------------------
// rtnb_back
// stores loaded keys and runs direction, range and split searches over them
// ----------------------------------------------------------------------------
module rtnb_back import rtnb_pkg::*; (
	input  logic            clk,
	input  logic            arst_n,
	input  logic [CntW-1:0] object_count,
	input  logic            cmd_valid,
	input  cmd_t            cmd,
	output logic            cmd_pop,
	rtnb_rsp_if.source      rsp
);
	typedef enum logic [3:0] {
		S_IDLE, S_DIR_A, S_DIR_B, S_DIR_C, S_BOUND, S_BOUND_W, S_SRCH, S_SRCH_W,
		S_SPL0, S_SPL1, S_SPL2, S_SPL_W, S_DONE
	} state_t;

	logic [KeyW-1:0] mem [MaxObjects];
	logic [KeyW-1:0] rd_data_q;
	logic [IdxW-1:0] rd_addr;

	state_t                  state_q;
	logic signed [SIdxW-1:0] idx_q, n_q, dir_q, bound_q, len_q, stride_q, pos_q, lo_q, hi_q;
	logic signed [SIdxW-1:0] probe_q;
	logic signed [7:0]       pl_l_q, dmin_q;
	logic [5:0]              base_q;
	logic [KeyW-1:0]         ki_q, kf_q;
	logic                    probe_ok_q;
	logic                    rvalid_q;
	res_t                    res_q;

	logic signed [SIdxW-1:0] nsat, cand, pos_ext;
	logic signed [7:0]       pl;
	logic [5:0]              lz_f;
	logic                    bad_idx, res_load;

	assign nsat = (object_count > CntW'(MaxObjects)) ? SIdxW'(MaxObjects) :
		SIdxW'(object_count);
	assign pos_ext = SIdxW'(cmd.position);
	assign bad_idx = (pos_ext + SIdxW'(1) >= nsat);

	// prefix length of ki against the key just read at probe_q
	always_comb begin
		if (!probe_ok_q) pl = -8'sd1;
		else if (rd_data_q == ki_q)
			pl = 8'sd32 + 8'(lzc32(32'(idx_q[IdxW-1:0] ^ probe_q[IdxW-1:0])));
		else pl = 8'(lzc32(rd_data_q ^ ki_q));
	end
	assign lz_f = lzc32(kf_q ^ rd_data_q);

	always_ff @(posedge clk) begin
		if (cmd_valid && state_q == S_IDLE && !cmd.is_query)
			mem[cmd.position] <= cmd.key_value;
		rd_data_q <= mem[rd_addr];
	end

	// helper: whether index p lies within 0 to n-1
	function automatic logic pin(input logic signed [SIdxW-1:0] p,
		input logic signed [SIdxW-1:0] n);
		return (p >= SIdxW'(0)) && (p < n);
	endfunction

	assign cmd_pop = (state_q == S_IDLE) && cmd_valid &&
		(!cmd.is_query || !rvalid_q || rsp.ready);

	// result register loads on a bad node index or a finished query
	assign res_load = (cmd_pop && cmd.is_query && bad_idx) ||
		(state_q == S_DONE && (!rvalid_q || rsp.ready));

	always_comb begin
		rd_addr = probe_q[IdxW-1:0];
		if (state_q == S_IDLE) rd_addr = cmd.position;
	end

	assign cand = pos_q + ((stride_q + SIdxW'(1)) >>> 1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			rvalid_q <= 1'b0;
		end else begin
			if (res_load) rvalid_q <= 1'b1;
			else if (rsp.ready) rvalid_q <= 1'b0;
			unique case (state_q)
				S_IDLE: if (cmd_pop && cmd.is_query) begin
					idx_q <= pos_ext;
					n_q   <= nsat;
					if (bad_idx) begin
						res_q <= '{status: ST_BAD_IDX, default: '0};
					end else begin
						probe_q    <= pos_ext - SIdxW'(1);
						probe_ok_q <= (cmd.position != '0);
						state_q    <= S_DIR_A;
					end
				end
				S_DIR_A: begin  // rd_data_q = key idx
					ki_q    <= rd_data_q;
					state_q <= S_DIR_B;
				end
				S_DIR_B: begin  // issued idx-1 or idx+1 already; wait data
					state_q <= S_DIR_C;
				end
				S_DIR_C: begin
					if (probe_q == idx_q - SIdxW'(1)) begin
						pl_l_q     <= pl;
						probe_q    <= idx_q + SIdxW'(1);
						probe_ok_q <= pin(idx_q + SIdxW'(1), n_q);
						state_q    <= S_DIR_B;
					end else begin
						if (pl_l_q > pl) begin
							dir_q <= SIdxW'(-1); dmin_q <= pl;
							probe_q <= idx_q - SIdxW'(2);
							probe_ok_q <= pin(idx_q - SIdxW'(2), n_q);
						end else begin
							dir_q <= SIdxW'(1); dmin_q <= pl_l_q;
							probe_q <= idx_q + SIdxW'(2);
							probe_ok_q <= pin(idx_q + SIdxW'(2), n_q);
						end
						bound_q <= SIdxW'(2);
						state_q <= S_BOUND_W;
					end
				end
				S_BOUND_W: state_q <= S_BOUND;
				S_BOUND: begin
					if (pl > dmin_q) begin
						bound_q    <= bound_q <<< 1;
						probe_q    <= idx_q + dir_q * (bound_q <<< 1);
						probe_ok_q <= pin(idx_q + dir_q * (bound_q <<< 1), n_q);
						state_q    <= S_BOUND_W;
					end else begin
						len_q      <= '0;
						stride_q   <= bound_q >>> 1;
						probe_q    <= idx_q + dir_q * (bound_q >>> 1);
						probe_ok_q <= pin(idx_q + dir_q * (bound_q >>> 1), n_q);
						state_q    <= S_SRCH_W;
					end
				end
				S_SRCH_W: state_q <= S_SRCH;
				S_SRCH: begin
					logic signed [SIdxW-1:0] nl, ns, f;
					nl = (pl > dmin_q) ? len_q + stride_q : len_q;
					ns = stride_q >>> 1;
					len_q <= nl;
					if (stride_q > SIdxW'(1)) begin
						stride_q   <= ns;
						probe_q    <= idx_q + (nl + ns) * dir_q;
						probe_ok_q <= pin(idx_q + (nl + ns) * dir_q, n_q);
						state_q    <= S_SRCH_W;
					end else begin
						f = idx_q + nl * dir_q;
						lo_q <= (f < idx_q) ? f : idx_q;
						hi_q <= (f < idx_q) ? idx_q : f;
						probe_q <= (f < idx_q) ? f : idx_q;
						state_q <= S_SPL0;
					end
				end
				S_SPL0: begin
					probe_q <= hi_q;
					state_q <= S_SPL1;
				end
				S_SPL1: begin  // rd_data_q = key lo
					kf_q    <= rd_data_q;
					state_q <= S_SPL2;
				end
				S_SPL2: begin  // rd_data_q = key hi
					if (rd_data_q == kf_q) begin
						pos_q   <= (lo_q + hi_q) >>> 1;
						state_q <= S_DONE;
					end else begin
						base_q     <= lz_f;
						pos_q      <= lo_q;
						stride_q   <= hi_q - lo_q;
						probe_q    <= lo_q + ((hi_q - lo_q + SIdxW'(1)) >>> 1);
						probe_ok_q <= 1'b0;
						state_q    <= S_SPL_W;
					end
				end
				S_SPL_W: begin  // wait for the read data, then evaluate
					if (probe_ok_q) begin
						logic signed [SIdxW-1:0] st, np;
						st = (stride_q + SIdxW'(1)) >>> 1;
						np = (cand < hi_q && lz_f > base_q) ? cand : pos_q;
						pos_q      <= np;
						stride_q   <= st;
						probe_ok_q <= 1'b0;
						if (st > SIdxW'(1)) probe_q <= np + ((st + SIdxW'(1)) >>> 1);
						else state_q <= S_DONE;
					end else probe_ok_q <= 1'b1;
				end
				S_DONE: if (!rvalid_q || rsp.ready) begin
					res_q.range_first          <= lo_q[IdxW-1:0];
					res_q.range_last           <= hi_q[IdxW-1:0];
					res_q.split_position       <= pos_q[IdxW-1:0];
					res_q.first_child_is_leaf  <= (pos_q == lo_q);
					res_q.second_child_is_leaf <= (pos_q + SIdxW'(1) == hi_q);
					res_q.status               <= ST_OK;
					state_q  <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign rsp.valid                = rvalid_q;
	assign rsp.range_first          = res_q.range_first;
	assign rsp.range_last           = res_q.range_last;
	assign rsp.split_position       = res_q.split_position;
	assign rsp.first_child_is_leaf  = res_q.first_child_is_leaf;
	assign rsp.second_child_is_leaf = res_q.second_child_is_leaf;
	assign rsp.status               = res_q.status;
endmodule

// ===== rtl/core/radix_tree_node_builder_core.sv =====
// ----------------------------------------------------------------------------
// radix_tree_node_builder_core
// builds binary radix tree internal nodes over sorted 32-bit keys
// ----------------------------------------------------------------------------
// usage:
//   req channel carries load items (req_type 0: write key_value at position)
//   and query items (req_type 1: build internal node at position)
//   rsp channel returns one item per query, none per load; the user must
//   write object_count via cfg_we/cfg_data only while idle; not enforced
// operation:
//   a load is a single write in the back end; a query runs the direction,
//   bound, range and split searches with one key probe at a time (single
//   read port); items are handled one at a time
//   a two-entry queue decouples the request side from the sequencer
// reset:
//   arst_n clears the queue and sequencer; object_count returns to 2;
//   key store contents are undefined until written
// stall:
//   the result register holds while rsp.ready is low; the sequencer waits
//   before finishing the next query, and the queue then fills and drops ready
// ----------------------------------------------------------------------------
module radix_tree_node_builder_core import rtnb_pkg::*; (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            cfg_we,
	input  logic [CntW-1:0] cfg_data,
	rtnb_req_if.sink        req,
	rtnb_rsp_if.source      rsp
);
	logic [CntW-1:0] object_count_q;
	logic            cmd_valid, cmd_pop;
	cmd_t            cmd;

	// object count register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) object_count_q <= CntW'(2);
		else if (cfg_we) object_count_q <= cfg_data;
	end

	rtnb_front u_front (
		.clk, .arst_n, .req, .cmd_valid, .cmd, .cmd_pop
	);

	rtnb_back u_back (
		.clk, .arst_n, .object_count(object_count_q), .cmd_valid, .cmd, .cmd_pop, .rsp
	);
endmodule
